FILE: rtl/ffra_pkg.sv
package ffra_pkg;

  localparam int unsigned MaxRegions = 64;
  localparam int unsigned IdxW       = $clog2(MaxRegions);
  localparam int unsigned PtrW       = IdxW + 1;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned LenW       = 48;
  localparam int unsigned StatW      = 3;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [PtrW-1:0] NilPtr = PtrW'(MaxRegions);

  typedef enum logic [StatW-1:0] {
    StOk        = 3'd0,
    StNoSpace   = 3'd1,
    StTableFull = 3'd2,
    StUnknown   = 3'd3,
    StZeroSize  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBase = 1'b0,
    CfgSize = 1'b1
  } cfg_reg_e;

  // Link fields of one table entry; kept together in one memory word.
  typedef struct packed {
    logic [PtrW-1:0] aprev;
    logic [PtrW-1:0] anext;
    logic [PtrW-1:0] fprev;
    logic [PtrW-1:0] fnext;
  } links_t;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  len;
    links_t           lk;
  } entry_t;

  function automatic logic ptr_ok(input logic [PtrW-1:0] p);
    return p < NilPtr;
  endfunction

endpackage

FILE: rtl/first_fit_region_allocator.sv
// Channel   | valid / ready            | payload
// ----------+--------------------------+-------------------------------------
// in        | in_valid_i / in_ready_o  | cmd_i, alloc_size_i, free_address_i
// out       | out_valid_o / out_ready_i| result_address_o, status_o
// cfg       | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item at a time. The region table lives in one synchronous memory with
// one read and one write port. An allocate walks the free list from its head,
// reading and comparing one entry per step; an exact fit then unlinks it, a
// split searches up to 64 entries for a spare one and patches the links.
// A free scans the table, reading only the entries that hold a used region,
// then merges with free neighbours and pushes the region onto the free list.
// The read-modify-write sequencer sets the order of these steps.
// After reset the first cycle writes entry 0 with both ready outputs low, and
// every configuration write loads a one-region table: only entry 0 is
// written, the per-entry in-use and free bits are flops.
// A finished result sits in the output register while the next item is
// already accepted and processed; that item's result waits in S_DONE until
// the earlier one is taken. An input item waits while a configuration write
// is offered.
module first_fit_region_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [ffra_pkg::LenW-1:0]     alloc_size_i,
  input  logic [ffra_pkg::AddrW-1:0]    free_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffra_pkg::AddrW-1:0]    result_address_o,
  output logic [ffra_pkg::StatW-1:0]    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffra_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ffra_pkg::AddrW-1:0]    cfg_data_i
);

  localparam int unsigned N  = ffra_pkg::MaxRegions;
  localparam int unsigned IW = ffra_pkg::IdxW;
  localparam int unsigned PW = ffra_pkg::PtrW;
  localparam int unsigned AW = ffra_pkg::AddrW;
  localparam int unsigned LW = ffra_pkg::LenW;

  // The sequencer. Each R state issues a read; the following state sees the
  // registered data. Writes are issued by W states, one entry each.
  typedef enum logic [20:0] {
    S_IDLE   = 21'd1 << 0,
    S_AREAD  = 21'd1 << 1,   // read free-list candidate
    S_ACHK   = 21'd1 << 2,   // compare its length
    S_SPARE  = 21'd1 << 3,   // find an unused entry, one per cycle
    S_SPW    = 21'd1 << 4,   // write the spare entry, read addr next
    S_SPAN   = 21'd1 << 5,   // patch addr next's prev, read free prev
    S_SPFP   = 21'd1 << 6,   // patch free prev's next, read free next
    S_SPFN   = 21'd1 << 7,   // patch free next's prev, update r's copy
    S_FSCAN  = 21'd1 << 8,   // read entry i for the address match
    S_FCHK   = 21'd1 << 9,
    S_FP     = 21'd1 << 10,  // p read back
    S_FPN    = 21'd1 << 11,  // patch n.aprev
    S_UNL    = 21'd1 << 12,  // unlink: read free prev of the victim
    S_UNLP   = 21'd1 << 13,
    S_UNLN   = 21'd1 << 14,
    S_FR     = 21'd1 << 15,  // re-read r
    S_FN     = 21'd1 << 16,  // n read back
    S_FNN    = 21'd1 << 17,  // patch nn.aprev
    S_PUSH   = 21'd1 << 18,  // re-read r, push to head
    S_PUSHH  = 21'd1 << 19,  // write r as the new head, read old head
    S_DONE   = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;

  // Table memory and registered read.
  ffra_pkg::entry_t mem_q [N];
  ffra_pkg::entry_t rd_q;
  logic             we;
  logic [IW-1:0]    wa, ra;
  ffra_pkg::entry_t wd;
  logic             re;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  // Per-entry flags and head pointer.
  logic [N-1:0]     used_q, used_d, free_q, free_d;
  logic [PW-1:0]    head_q, head_d;
  logic [AW-1:0]    cbase_q, cbase_d;
  logic [LW-1:0]    csize_q, csize_d;
  logic             init_q;         // entry 0 still to be written after reset

  // Working registers of the current item.
  logic [LW-1:0]    size_q;
  logic [AW-1:0]    faddr_q;
  logic [PW-1:0]    r_q, r_d;       // region being handled
  logic [PW-1:0]    cur_q, cur_d;   // walk or scan pointer
  logic [PW-1:0]    x_q, x_d;       // spare entry / victim of unlink
  logic [PW-1:0]    cnt_q, cnt_d;
  ffra_pkg::entry_t r_e_q, r_e_d;   // copy of entry r
  ffra_pkg::entry_t x_e_q, x_e_d;   // copy of the other entry
  logic [1:0]       ret_q, ret_d;   // where an unlink returns
  logic [PW-1:0]    fp_q, fp_d, fn_q, fn_d;
  logic [AW-1:0]    res_q, res_d;
  logic [2:0]       st_q, st_d;
  logic             ov_q, ov_d;

  // Output register of the result item.
  logic [AW-1:0]    oaddr_q;
  logic [2:0]       ost_q;

  localparam logic [1:0] RetP     = 2'd0;
  localparam logic [1:0] RetN     = 2'd1;
  localparam logic [1:0] RetOk    = 2'd2;
  localparam logic [1:0] RetSplit = 2'd3;

  logic [IW-1:0] cur_i, r_i, x_i;
  assign cur_i = cur_q[IW-1:0];
  assign r_i   = r_q[IW-1:0];
  assign x_i   = x_q[IW-1:0];

  assign in_ready_o       = (state_q == S_IDLE) && !init_q && !cfg_valid_i;
  assign cfg_ready_o      = (state_q == S_IDLE) && !ov_q && !init_q;
  assign out_valid_o      = ov_q;
  assign result_address_o = oaddr_q;
  assign status_o         = ost_q;

  logic in_acc, cfg_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    free_d  = free_q;
    head_d  = head_q;
    cbase_d = cbase_q;
    csize_d = csize_q;
    r_d     = r_q;
    cur_d   = cur_q;
    x_d     = x_q;
    cnt_d   = cnt_q;
    r_e_d   = r_e_q;
    x_e_d   = x_e_q;
    ret_d   = ret_q;
    fp_d    = fp_q;
    fn_d    = fn_q;
    res_d   = res_q;
    st_d    = st_q;
    ov_d    = ov_q;
    we      = 1'b0;
    wa      = '0;
    wd      = rd_q;
    re      = 1'b0;
    ra      = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (init_q) begin
          // First cycle after reset: load entry 0 with the reset range.
          we = 1'b1;
          wa = '0;
          wd.base = cbase_q;
          wd.len  = csize_q;
          wd.lk   = '{ffra_pkg::NilPtr, ffra_pkg::NilPtr,
                      ffra_pkg::NilPtr, ffra_pkg::NilPtr};
        end else if (cfg_acc) begin
          if (cfg_index_i == ffra_pkg::CfgBase) begin
            cbase_d = cfg_data_i;
          end else begin
            csize_d = cfg_data_i[LW-1:0];
          end
          used_d = N'(1);
          free_d = N'(1);
          head_d = '0;
          we = 1'b1;
          wa = '0;
          wd.base = (cfg_index_i == ffra_pkg::CfgBase) ? cfg_data_i : cbase_q;
          wd.len  = (cfg_index_i == ffra_pkg::CfgBase) ? csize_q
                                                       : cfg_data_i[LW-1:0];
          wd.lk   = '{ffra_pkg::NilPtr, ffra_pkg::NilPtr,
                      ffra_pkg::NilPtr, ffra_pkg::NilPtr};
        end else if (in_acc) begin
          res_d = '0;
          cnt_d = '0;
          if (cmd_i == ffra_pkg::CmdFree) begin
            cur_d   = '0;
            state_d = S_FSCAN;
          end else if (alloc_size_i == '0) begin
            st_d = ffra_pkg::StZeroSize;
            state_d = S_DONE;
          end else begin
            cur_d   = head_q;
            state_d = S_AREAD;
          end
        end
      end
      // ---------------- allocate ----------------
      S_AREAD: begin
        if (!ffra_pkg::ptr_ok(cur_q) || cnt_q == PW'(N)) begin
          cnt_d = '0;
          st_d = ffra_pkg::StNoSpace;
          state_d = S_DONE;
        end else begin
          re = 1'b1;
          ra = cur_i;
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        if (size_q <= rd_q.len) begin
          r_d   = cur_q;
          r_e_d = rd_q;
          res_d = rd_q.base;
          cnt_d = '0;
          if (size_q == rd_q.len) begin
            // Exact fit: unlink r and return.
            free_d[cur_i] = 1'b0;
            x_d   = cur_q;
            x_e_d = rd_q;
            ret_d = RetOk;
            state_d = S_UNL;
          end else begin
            cur_d = '0;
            state_d = S_SPARE;
          end
        end else begin
          cur_d = rd_q.lk.fnext;
          cnt_d = cnt_q + PW'(1);
          state_d = S_AREAD;
        end
      end
      S_SPARE: begin
        if (cur_q == PW'(N)) begin
          res_d = '0;
          st_d = ffra_pkg::StTableFull;
          state_d = S_DONE;
        end else if (!used_q[cur_i]) begin
          x_d = cur_q;
          state_d = S_SPW;
        end else begin
          cur_d = cur_q + PW'(1);
        end
      end
      S_SPW: begin
        used_d[x_i] = 1'b1;
        free_d[x_i] = 1'b1;
        free_d[r_i] = 1'b0;
        we = 1'b1;
        wa = x_i;
        wd.base = r_e_q.base + AW'(size_q);
        wd.len  = r_e_q.len - size_q;
        wd.lk   = '{r_q, r_e_q.lk.anext, r_e_q.lk.fprev, r_e_q.lk.fnext};
        if (head_q == r_q) begin
          head_d = x_q;
        end
        re = 1'b1;
        ra = r_e_q.lk.anext[IW-1:0];
        state_d = S_SPAN;
      end
      S_SPAN: begin
        if (ffra_pkg::ptr_ok(r_e_q.lk.anext)) begin
          we = 1'b1;
          wa = r_e_q.lk.anext[IW-1:0];
          wd = rd_q;
          wd.lk.aprev = x_q;
        end
        re = 1'b1;
        ra = r_e_q.lk.fprev[IW-1:0];
        state_d = S_SPFP;
      end
      S_SPFP: begin
        if (ffra_pkg::ptr_ok(r_e_q.lk.fprev)) begin
          we = 1'b1;
          wa = r_e_q.lk.fprev[IW-1:0];
          wd = rd_q;
          wd.lk.fnext = x_q;
        end
        re = 1'b1;
        ra = r_e_q.lk.fnext[IW-1:0];
        state_d = S_SPFN;
      end
      S_SPFN: begin
        if (ffra_pkg::ptr_ok(r_e_q.lk.fnext)) begin
          we = 1'b1;
          wa = r_e_q.lk.fnext[IW-1:0];
          wd = rd_q;
          wd.lk.fprev = x_q;
          // r itself is written in S_FR.
        end
        r_e_d = r_e_q;
        r_e_d.len = size_q;
        r_e_d.lk.anext = x_q;
        r_e_d.lk.fprev = ffra_pkg::NilPtr;
        r_e_d.lk.fnext = ffra_pkg::NilPtr;
        ret_d = RetSplit;
        state_d = S_FR;
      end
      // ---------------- free ----------------
      S_FSCAN: begin
        if (cur_q == PW'(N)) begin
          st_d = ffra_pkg::StUnknown;
          state_d = S_DONE;
        end else if (used_q[cur_i] && !free_q[cur_i]) begin
          re = 1'b1;
          ra = cur_i;
          state_d = S_FCHK;
        end else begin
          cur_d = cur_q + PW'(1);
        end
      end
      S_FCHK: begin
        if (rd_q.base == faddr_q) begin
          r_d   = cur_q;
          r_e_d = rd_q;
          re = 1'b1;
          ra = rd_q.lk.aprev[IW-1:0];
          state_d = S_FP;
        end else begin
          cur_d = cur_q + PW'(1);
          state_d = S_FSCAN;
        end
      end
      S_FP: begin
        if (ffra_pkg::ptr_ok(r_e_q.lk.aprev) &&
            free_q[r_e_q.lk.aprev[IW-1:0]]) begin
          // Merge r into p; p becomes the region.
          used_d[r_i] = 1'b0;
          x_d   = r_e_q.lk.aprev;
          x_e_d = rd_q;
          x_e_d.len = rd_q.len + r_e_q.len;
          x_e_d.lk.anext = r_e_q.lk.anext;
          re = 1'b1;
          ra = r_e_q.lk.anext[IW-1:0];
          state_d = S_FPN;
        end else begin
          re = 1'b1;
          ra = r_e_q.lk.anext[IW-1:0];
          state_d = S_FN;
        end
      end
      S_FPN: begin
        if (ffra_pkg::ptr_ok(r_e_q.lk.anext)) begin
          we = 1'b1;
          wa = r_e_q.lk.anext[IW-1:0];
          wd = rd_q;
          wd.lk.aprev = x_q;
        end
        free_d[x_i] = 1'b0;
        ret_d = RetP;
        state_d = S_UNL;
      end
      // Unlink x (copy in x_e_q) from the free list: write x back, then patch its neighbours.
      S_UNL: begin
        fp_d = x_e_q.lk.fprev;
        fn_d = x_e_q.lk.fnext;
        if (head_q == x_q) begin
          head_d = x_e_q.lk.fnext;
        end
        we = 1'b1;
        wa = x_i;
        wd = x_e_q;
        wd.lk.fprev = ffra_pkg::NilPtr;
        wd.lk.fnext = ffra_pkg::NilPtr;
        x_e_d = wd;
        re = 1'b1;
        ra = x_e_q.lk.fprev[IW-1:0];
        state_d = S_UNLP;
      end
      S_UNLP: begin
        if (ffra_pkg::ptr_ok(fp_q)) begin
          we = 1'b1;
          wa = fp_q[IW-1:0];
          wd = rd_q;
          wd.lk.fnext = fn_q;
        end
        re = 1'b1;
        ra = fn_q[IW-1:0];
        state_d = S_UNLN;
      end
      S_UNLN: begin
        if (ffra_pkg::ptr_ok(fn_q)) begin
          we = 1'b1;
          wa = fn_q[IW-1:0];
          wd = rd_q;
          wd.lk.fprev = fp_q;
        end
        case (ret_q)
          RetP: begin
            r_d = x_q;
            re = 1'b1;
            ra = x_i;
            state_d = S_FR;
          end
          RetN: begin
            state_d = S_PUSH;
          end
          default: begin
            st_d = ffra_pkg::StOk;
            state_d = S_DONE;
          end
        endcase
      end
      S_FR: begin
        if (ret_q == RetSplit) begin
          // End of a split: write r and finish.
          we = 1'b1;
          wa = r_i;
          wd = r_e_q;
          st_d = ffra_pkg::StOk;
          state_d = S_DONE;
        end else begin
          r_e_d = rd_q;
          re = 1'b1;
          ra = rd_q.lk.anext[IW-1:0];
          state_d = S_FN;
        end
      end
      S_FN: begin
        if (ffra_pkg::ptr_ok(r_e_q.lk.anext) &&
            free_q[r_e_q.lk.anext[IW-1:0]]) begin
          used_d[r_e_q.lk.anext[IW-1:0]] = 1'b0;
          free_d[r_e_q.lk.anext[IW-1:0]] = 1'b0;
          x_d   = r_e_q.lk.anext;
          x_e_d = rd_q;
          x_e_d.lk.aprev = ffra_pkg::NilPtr;
          x_e_d.lk.anext = ffra_pkg::NilPtr;
          r_e_d.len = r_e_q.len + rd_q.len;
          r_e_d.lk.anext = rd_q.lk.anext;
          we = 1'b1;
          wa = r_i;
          wd = r_e_q;
          wd.len = r_e_q.len + rd_q.len;
          wd.lk.anext = rd_q.lk.anext;
          re = 1'b1;
          ra = rd_q.lk.anext[IW-1:0];
          state_d = S_FNN;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_FNN: begin
        if (ffra_pkg::ptr_ok(r_e_q.lk.anext)) begin
          we = 1'b1;
          wa = r_e_q.lk.anext[IW-1:0];
          wd = rd_q;
          wd.lk.aprev = r_q;
        end
        ret_d = RetN;
        state_d = S_UNL;
      end
      S_PUSH: begin
        // Re-read r: the unlink may have touched its free links.
        re = 1'b1;
        ra = r_i;
        state_d = S_PUSHH;
      end
      S_PUSHH: begin
        free_d[r_i] = 1'b1;
        we = 1'b1;
        wa = r_i;
        wd = rd_q;
        wd.lk.fnext = head_q;
        wd.lk.fprev = ffra_pkg::NilPtr;
        head_d = r_q;
        fn_d = head_q;
        re = 1'b1;
        ra = head_q[IW-1:0];
        ret_d = RetOk;
        x_d = r_q;
        state_d = S_DONE;
        st_d = ffra_pkg::StOk;
        cnt_d = PW'(1);
      end
      S_DONE: begin
        if (cnt_q == PW'(1)) begin
          // Tail of a push: fix the old head's back link. Repeating it while
          // the result waits writes the same word again.
          if (ffra_pkg::ptr_ok(fn_q)) begin
            we = 1'b1;
            wa = fn_q[IW-1:0];
            wd = rd_q;
            wd.lk.fprev = x_q;
          end
        end
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= N'(1);
      free_q  <= N'(1);
      head_q  <= '0;
      cbase_q <= '0;
      csize_q <= LW'(64'h1_0000_0000);
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      free_q  <= free_d;
      head_q  <= head_d;
      cbase_q <= cbase_d;
      csize_q <= csize_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  // Entry 0 after reset: the flags already say in use and free, and the
  // memory word is written on the first idle cycle, with both readies low.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
    end else if (init_q) begin
      init_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      size_q  <= alloc_size_i;
      faddr_q <= free_address_i;
    end
    if (state_q == S_DONE && (!ov_q || out_ready_i)) begin
      oaddr_q <= res_q;
      ost_q   <= st_q;
    end
    r_q   <= r_d;
    cur_q <= cur_d;
    x_q   <= x_d;
    r_e_q <= r_e_d;
    x_e_q <= x_e_d;
    ret_q <= ret_d;
    fp_q  <= fp_d;
    fn_q  <= fn_d;
    res_q <= res_d;
    st_q  <= st_d;
  end

endmodule
